// ===== src/dns_response_address_extractor_macros.svh =====
// assertion macros for the dns response address extractor checker
// depends on a signal named clock and a signal named reset in the using scope
`ifndef DNS_RESPONSE_ADDRESS_EXTRACTOR_MACROS_SVH
`define DNS_RESPONSE_ADDRESS_EXTRACTOR_MACROS_SVH

// checked at every edge, reset included
`define DRE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

// checked only outside reset
`define DRE_ASSERT_RUN(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ===== src/dre_pkg.sv =====
// shared types and constants for the dns response address extractor
// no dependencies
package dre_pkg;

   localparam int MAX_MESSAGE_BYTES = 512;
   localparam int POS_WIDTH         = $clog2(MAX_MESSAGE_BYTES + 2);

   // status codes
   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_TOO_SHORT    = 4'd1;
   localparam logic [3:0] ST_NOT_RESPONSE = 4'd2;
   localparam logic [3:0] ST_SERVER_ERROR = 4'd3;
   localparam logic [3:0] ST_BAD_COUNTS   = 4'd4;
   localparam logic [3:0] ST_BAD_LABEL    = 4'd5;
   localparam logic [3:0] ST_TRUNCATED    = 4'd6;
   localparam logic [3:0] ST_NO_ADDRESS   = 4'd7;
   localparam logic [3:0] ST_TOO_LONG     = 4'd8;

   // register indexes
   localparam logic CSR_MAX_ANSWERS   = 1'b0;
   localparam logic CSR_MAX_QUESTIONS = 1'b1;

   localparam logic [7:0] MAX_ANSWERS_RESET   = 8'd20;
   localparam logic [7:0] MAX_QUESTIONS_RESET = 8'd10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  status;
      logic        is_ipv6;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
   } rsp_payload_type;

endpackage

// ===== src/dns_response_address_extractor.sv =====
// top level of the dns response address extractor: byte-serial dns response parser
// depends on dre_pkg
//
// throughput: one message byte per cycle while req_stall is low, no bubbles between messages
// result: registered, shown in the cycle after the last byte is accepted
// req_stall rises only for a last byte while the previous result still waits
// reset: synchronous, active high; registers return to 20 and 10, parser to header
module dns_response_address_extractor (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dre_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output dre_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write,
   input  logic                     csr_index,
   input  logic [7:0]               csr_data
);

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_QNAME,
      PH_QLABEL,
      PH_QPTR,
      PH_QFIXED,
      PH_ANAME,
      PH_ALABEL,
      PH_APTR,
      PH_AFIXED,
      PH_ARDATA,
      PH_DONE
   } phase_type;

   localparam logic [dre_pkg::POS_WIDTH-1:0] MAX_POS =
      dre_pkg::POS_WIDTH'(dre_pkg::MAX_MESSAGE_BYTES);
   localparam logic [dre_pkg::POS_WIDTH-1:0] HEADER_BYTES = dre_pkg::POS_WIDTH'(12);
   // header byte positions
   localparam logic [dre_pkg::POS_WIDTH-1:0] POS_FLAGS_HI = dre_pkg::POS_WIDTH'(2);
   localparam logic [dre_pkg::POS_WIDTH-1:0] POS_FLAGS_LO = dre_pkg::POS_WIDTH'(3);
   localparam logic [dre_pkg::POS_WIDTH-1:0] POS_QD_HI    = dre_pkg::POS_WIDTH'(4);
   localparam logic [dre_pkg::POS_WIDTH-1:0] POS_QD_LO    = dre_pkg::POS_WIDTH'(5);
   localparam logic [dre_pkg::POS_WIDTH-1:0] POS_AN_HI    = dre_pkg::POS_WIDTH'(6);
   localparam logic [dre_pkg::POS_WIDTH-1:0] POS_AN_LO    = dre_pkg::POS_WIDTH'(7);
   localparam logic [dre_pkg::POS_WIDTH-1:0] POS_HDR_END  = dre_pkg::POS_WIDTH'(11);

   localparam logic [15:0] QUESTION_TAIL = 16'd4;
   localparam logic [15:0] ANSWER_FIXED  = 16'd10;
   localparam logic [15:0] TYPE_A        = 16'd1;
   localparam logic [15:0] TYPE_AAAA     = 16'd28;
   localparam logic [15:0] LEN_A         = 16'd4;
   localparam logic [15:0] LEN_AAAA      = 16'd16;
   // bytes_left values for the type and rdlength bytes of the fixed answer part
   localparam logic [15:0] LEFT_TYPE_HI  = 16'd10;
   localparam logic [15:0] LEFT_TYPE_LO  = 16'd9;
   localparam logic [15:0] LEFT_LEN_HI   = 16'd2;
   localparam logic [15:0] LEFT_LEN_LO   = 16'd1;

   localparam logic [7:0] LABEL_MAX   = 8'd63;
   localparam logic [7:0] POINTER_MIN = 8'hC0;

   // configuration
   logic [7:0] max_answers_ff;
   logic [7:0] max_questions_ff;

   // per-message parser state
   phase_type                    phase_ff,         phase_in;
   logic [dre_pkg::POS_WIDTH-1:0] pos_ff,           pos_in;
   logic [15:0]                  flags_ff,         flags_in;
   logic [7:0]                   questions_ff,     questions_in;
   logic [7:0]                   answers_ff,       answers_in;
   logic [15:0]                  bytes_left_ff,    bytes_left_in;
   logic [15:0]                  record_type_ff,   record_type_in;
   logic [15:0]                  record_length_ff, record_length_in;
   logic [63:0]                  addr_upper_ff,    addr_upper_in;
   logic [63:0]                  addr_lower_ff,    addr_lower_in;
   logic [3:0]                   outcome_ff,       outcome_in;

   // result register
   logic                     rsp_valid_ff;
   dre_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic       req_xfer;
   logic       last_xfer;
   logic [7:0] b;

   assign b         = req_payload.data_byte;
   // non-last bytes give no result, so only a last byte has to wait for the output slot
   assign req_stall = rsp_valid_ff && rsp_stall && req_payload.last_byte;
   assign req_xfer  = req_valid && !req_stall;
   assign last_xfer = req_xfer && req_payload.last_byte;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // next parser state for the byte on the input
   always_comb begin
      logic          parse;
      logic          in_answer;
      logic          rec_match;
      logic [7:0]    answers_dec;
      logic [15:0]   length_full;
      logic [127:0]  addr_shift;
      logic [3:0]    status;
      logic          ok;

      phase_in         = phase_ff;
      flags_in         = flags_ff;
      questions_in     = questions_ff;
      answers_in       = answers_ff;
      bytes_left_in    = bytes_left_ff;
      record_type_in   = record_type_ff;
      record_length_in = record_length_ff;
      addr_upper_in    = addr_upper_ff;
      addr_lower_in    = addr_lower_ff;
      outcome_in       = outcome_ff;

      // counter saturates one past the limit so that too_long sticks
      pos_in    = (pos_ff <= MAX_POS) ? pos_ff + 1'b1 : pos_ff;
      parse     = (phase_ff != PH_DONE) && (pos_ff < MAX_POS);
      in_answer = (phase_ff == PH_ANAME) || (phase_ff == PH_ALABEL);
      rec_match = ((record_type_ff == TYPE_A) && (record_length_ff == LEN_A)) ||
                  ((record_type_ff == TYPE_AAAA) && (record_length_ff == LEN_AAAA));
      answers_dec = answers_ff - 1'b1;
      length_full = {record_length_ff[15:8], b};
      addr_shift  = {addr_upper_ff[55:0], addr_lower_ff, b};

      if (parse) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == POS_FLAGS_HI) flags_in = {b, 8'h00};
               if (pos_ff == POS_FLAGS_LO) flags_in = {flags_ff[15:8], b};
               // question count parks in record_type, answer count in record_length
               if (pos_ff == POS_QD_HI) record_type_in = {b, 8'h00};
               if (pos_ff == POS_QD_LO) record_type_in = {record_type_ff[15:8], b};
               if (pos_ff == POS_AN_HI) record_length_in = {b, 8'h00};
               if (pos_ff == POS_AN_LO) record_length_in = {record_length_ff[15:8], b};
               if (pos_ff == POS_HDR_END) begin
                  priority if (!flags_ff[15]) begin
                     outcome_in = dre_pkg::ST_NOT_RESPONSE;
                     phase_in   = PH_DONE;
                  end else if (flags_ff[3:0] != 4'h0) begin
                     outcome_in = dre_pkg::ST_SERVER_ERROR;
                     phase_in   = PH_DONE;
                  end else if ((record_length_ff == 16'h0) ||
                               (record_length_ff > {8'h00, max_answers_ff})) begin
                     outcome_in = dre_pkg::ST_BAD_COUNTS;
                     phase_in   = PH_DONE;
                  end else if (record_type_ff > {8'h00, max_questions_ff}) begin
                     outcome_in = dre_pkg::ST_BAD_COUNTS;
                     phase_in   = PH_DONE;
                  end else begin
                     questions_in     = record_type_ff[7:0];
                     answers_in       = record_length_ff[7:0];
                     record_type_in   = 16'h0;
                     record_length_in = 16'h0;
                     phase_in = (record_type_ff[7:0] != 8'h0) ? PH_QNAME : PH_ANAME;
                  end
               end
            end
            PH_QNAME, PH_ANAME: begin
               priority if (b == 8'h00) begin
                  phase_in      = in_answer ? PH_AFIXED : PH_QFIXED;
                  bytes_left_in = in_answer ? ANSWER_FIXED : QUESTION_TAIL;
               end else if (b >= POINTER_MIN) begin
                  phase_in = in_answer ? PH_APTR : PH_QPTR;
               end else if (b > LABEL_MAX) begin
                  outcome_in = dre_pkg::ST_BAD_LABEL;
                  phase_in   = PH_DONE;
               end else begin
                  phase_in      = in_answer ? PH_ALABEL : PH_QLABEL;
                  bytes_left_in = {8'h00, b};
               end
            end
            PH_QLABEL, PH_ALABEL: begin
               bytes_left_in = bytes_left_ff - 1'b1;
               if (bytes_left_ff == 16'd1) phase_in = in_answer ? PH_ANAME : PH_QNAME;
            end
            PH_QPTR: begin
               phase_in      = PH_QFIXED;
               bytes_left_in = QUESTION_TAIL;
            end
            PH_QFIXED: begin
               bytes_left_in = bytes_left_ff - 1'b1;
               if (bytes_left_ff == 16'd1) begin
                  questions_in = questions_ff - 1'b1;
                  phase_in     = (questions_ff == 8'd1) ? PH_ANAME : PH_QNAME;
               end
            end
            PH_APTR: begin
               phase_in      = PH_AFIXED;
               bytes_left_in = ANSWER_FIXED;
            end
            PH_AFIXED: begin
               if (bytes_left_ff == LEFT_TYPE_HI) record_type_in = {b, 8'h00};
               if (bytes_left_ff == LEFT_TYPE_LO) record_type_in = {record_type_ff[15:8], b};
               if (bytes_left_ff == LEFT_LEN_HI) record_length_in = {b, 8'h00};
               bytes_left_in = bytes_left_ff - 1'b1;
               if (bytes_left_ff == LEFT_LEN_LO) begin
                  record_length_in = length_full;
                  addr_upper_in    = 64'h0;
                  addr_lower_in    = 64'h0;
                  if (length_full == 16'h0) begin
                     // empty record data: record is finished here
                     answers_in = answers_dec;
                     if (answers_dec == 8'h0) begin
                        outcome_in = dre_pkg::ST_NO_ADDRESS;
                        phase_in   = PH_DONE;
                     end else begin
                        phase_in = PH_ANAME;
                     end
                  end else begin
                     phase_in      = PH_ARDATA;
                     bytes_left_in = length_full;
                  end
               end
            end
            PH_ARDATA: begin
               if (rec_match) begin
                  addr_upper_in = addr_shift[127:64];
                  addr_lower_in = addr_shift[63:0];
               end
               bytes_left_in = bytes_left_ff - 1'b1;
               if (bytes_left_ff == 16'd1) begin
                  if (rec_match) begin
                     outcome_in = dre_pkg::ST_OK;
                     phase_in   = PH_DONE;
                  end else begin
                     answers_in = answers_dec;
                     if (answers_dec == 8'h0) begin
                        outcome_in = dre_pkg::ST_NO_ADDRESS;
                        phase_in   = PH_DONE;
                     end else begin
                        phase_in = PH_ANAME;
                     end
                  end
               end
            end
            default: begin
               // done: bytes after the decision are ignored
            end
         endcase
      end

      // final status, too_long wins over everything
      priority if (pos_in > MAX_POS) status = dre_pkg::ST_TOO_LONG;
      else if (pos_in < HEADER_BYTES) status = dre_pkg::ST_TOO_SHORT;
      else if (phase_in == PH_DONE)   status = outcome_in;
      else                            status = dre_pkg::ST_TRUNCATED;

      ok = (status == dre_pkg::ST_OK);
      rsp_payload_in.status    = status;
      rsp_payload_in.is_ipv6   = ok && (record_type_in == TYPE_AAAA);
      rsp_payload_in.addr_high = (ok && (record_type_in == TYPE_AAAA)) ? addr_upper_in : 64'h0;
      rsp_payload_in.addr_low  = ok ? addr_lower_in : 64'h0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_answers_ff   <= dre_pkg::MAX_ANSWERS_RESET;
         max_questions_ff <= dre_pkg::MAX_QUESTIONS_RESET;
         phase_ff         <= PH_HEADER;
         pos_ff           <= '0;
         flags_ff         <= '0;
         questions_ff     <= '0;
         answers_ff       <= '0;
         bytes_left_ff    <= '0;
         record_type_ff   <= '0;
         record_length_ff <= '0;
         addr_upper_ff    <= '0;
         addr_lower_ff    <= '0;
         outcome_ff       <= dre_pkg::ST_OK;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               dre_pkg::CSR_MAX_ANSWERS:   max_answers_ff   <= csr_data;
               dre_pkg::CSR_MAX_QUESTIONS: max_questions_ff <= csr_data;
               default: begin
               end
            endcase
         end

         if (last_xfer) begin
            // message ends: parser clears for the next one
            phase_ff         <= PH_HEADER;
            pos_ff           <= '0;
            flags_ff         <= '0;
            questions_ff     <= '0;
            answers_ff       <= '0;
            bytes_left_ff    <= '0;
            record_type_ff   <= '0;
            record_length_ff <= '0;
            addr_upper_ff    <= '0;
            addr_lower_ff    <= '0;
            outcome_ff       <= dre_pkg::ST_OK;
         end else if (req_xfer) begin
            phase_ff         <= phase_in;
            pos_ff           <= pos_in;
            flags_ff         <= flags_in;
            questions_ff     <= questions_in;
            answers_ff       <= answers_in;
            bytes_left_ff    <= bytes_left_in;
            record_type_ff   <= record_type_in;
            record_length_ff <= record_length_in;
            addr_upper_ff    <= addr_upper_in;
            addr_lower_ff    <= addr_lower_in;
            outcome_ff       <= outcome_in;
         end

         // result slot: loads on a last-byte transfer, drains when not stalled
         if (last_xfer)       rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end

      if (last_xfer) rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// ===== src/dre_checker.sv =====
// port-level checks for the dns response address extractor
// depends on dre_pkg and dns_response_address_extractor_macros.svh
`include "dns_response_address_extractor_macros.svh"

module dre_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input dre_pkg::rsp_payload_type rsp_payload
);

   `DRE_ASSERT(a_idle_after_reset, reset |=> !rsp_valid, "result valid right after reset")

   `DRE_ASSERT_RUN(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload), "stalled result changed")

   `DRE_ASSERT(a_stall_needs_result, req_stall |-> rsp_valid && rsp_stall, "input stalled with no result waiting")

   `DRE_ASSERT_RUN(a_fail_zero_addr, rsp_valid && (rsp_payload.status != dre_pkg::ST_OK) |-> !rsp_payload.is_ipv6 && (rsp_payload.addr_high == 64'h0) && (rsp_payload.addr_low == 64'h0), "address on a failed result")

   `DRE_ASSERT_RUN(a_ipv4_low_only, rsp_valid && (rsp_payload.status == dre_pkg::ST_OK) && !rsp_payload.is_ipv6 |-> (rsp_payload.addr_high == 64'h0) && (rsp_payload.addr_low[63:32] == 32'h0), "ipv4 address wider than 32 bits")

endmodule

bind dns_response_address_extractor dre_checker u_dre_checker (.*);

// ===== tb/sv/dre_tb_pkg.sv =====
`timescale 1ns / 100ps
// scoreboard for the dns response address extractor: byte-level parse prediction and result check
// depends on dre_pkg
package dre_tb_pkg;
   import dre_pkg::*;

   localparam int HEADER_LEN  = 12;
   localparam int Q_TAIL_LEN  = 4;
   localparam int A_FIXED_LEN = 10;
   localparam int LABEL_MAX   = 63;
   localparam int IPV4_BYTES  = 4;
   localparam int IPV6_BYTES  = 16;

   localparam logic [7:0]  POINTER_MIN   = 8'hC0;
   localparam logic [15:0] FLAG_QR       = 16'h8000;
   localparam logic [15:0] FLAG_RCODE    = 16'h000F;
   localparam logic [15:0] RR_TYPE_A     = 16'd1;
   localparam logic [15:0] RR_TYPE_CNAME = 16'd5;
   localparam logic [15:0] RR_TYPE_TXT   = 16'd16;
   localparam logic [15:0] RR_TYPE_AAAA  = 16'd28;

   typedef enum logic [3:0] {
      P_HEADER, P_Q_NAME, P_Q_LABEL, P_Q_POINTER, P_Q_TAIL,
      P_A_NAME, P_A_LABEL, P_A_POINTER, P_A_FIXED, P_A_RDATA, P_DECIDED
   } parse_phase_e;

   class dns_answer_scoreboard;
      logic [7:0]      max_answers;
      logic [7:0]      max_questions;
      parse_phase_e    phase;
      logic [9:0]      byte_count;
      logic [15:0]     flags;
      logic [7:0]      questions_left;
      logic [7:0]      answers_left;
      logic [15:0]     left_in_field;
      logic [15:0]     rr_type;
      logic [15:0]     rr_length;
      logic [63:0]     addr_upper;
      logic [63:0]     addr_lower;
      logic [3:0]      outcome;
      rsp_payload_type expected_q[$];
      int              error_count;

      function new();
         max_answers   = MAX_ANSWERS_RESET;
         max_questions = MAX_QUESTIONS_RESET;
         error_count   = 0;
         clear_message();
      endfunction

      function void write_register(logic index, logic [7:0] value);
         if (index == CSR_MAX_ANSWERS) begin
            max_answers = value;
         end else begin
            max_questions = value;
         end
      endfunction

      function void clear_message();
         phase          = P_HEADER;
         byte_count     = '0;
         flags          = '0;
         questions_left = '0;
         answers_left   = '0;
         left_in_field  = '0;
         rr_type        = '0;
         rr_length      = '0;
         addr_upper     = '0;
         addr_lower     = '0;
         outcome        = ST_OK;
      endfunction

      function void decide(logic [3:0] status);
         outcome = status;
         phase   = P_DECIDED;
      endfunction

      function bit address_record();
         return (rr_type == RR_TYPE_A && rr_length == IPV4_BYTES) ||
                (rr_type == RR_TYPE_AAAA && rr_length == IPV6_BYTES);
      endfunction

      // first byte of a name or of a label
      function void name_start(logic [7:0] b, parse_phase_e label_ph, parse_phase_e ptr_ph,
                               parse_phase_e fixed_ph, logic [15:0] fixed_len);
         if (b == 8'h00) begin
            phase         = fixed_ph;
            left_in_field = fixed_len;
         end else if (b >= POINTER_MIN) begin
            phase = ptr_ph;
         end else if (b > LABEL_MAX) begin
            decide(ST_BAD_LABEL);
         end else begin
            phase         = label_ph;
            left_in_field = {8'h00, b};
         end
      endfunction

      function void answer_done();
         answers_left = answers_left - 8'd1;
         if (answers_left == 0) begin
            decide(ST_NO_ADDRESS);
         end else begin
            phase = P_A_NAME;
         end
      endfunction

      function void walk_byte(int pos, logic [7:0] b);
         int idx;
         case (phase)
            P_HEADER: begin
               case (pos)
                  2: flags = {b, 8'h00};
                  3: flags[7:0] = b;
                  4: rr_type = {b, 8'h00};
                  5: rr_type[7:0] = b;
                  6: rr_length = {b, 8'h00};
                  7: rr_length[7:0] = b;
                  default: ;
               endcase
               // header counts sit in rr_type (questions) and rr_length (answers)
               if (pos == HEADER_LEN - 1) begin
                  if ((flags & FLAG_QR) == 0) begin
                     decide(ST_NOT_RESPONSE);
                  end else if ((flags & FLAG_RCODE) != 0) begin
                     decide(ST_SERVER_ERROR);
                  end else if (rr_length == 0 || rr_length > {8'h00, max_answers}) begin
                     decide(ST_BAD_COUNTS);
                  end else if (rr_type > {8'h00, max_questions}) begin
                     decide(ST_BAD_COUNTS);
                  end else begin
                     questions_left = rr_type[7:0];
                     answers_left   = rr_length[7:0];
                     rr_type        = '0;
                     rr_length      = '0;
                     phase = (questions_left != 0) ? P_Q_NAME : P_A_NAME;
                  end
               end
            end
            P_Q_NAME: name_start(b, P_Q_LABEL, P_Q_POINTER, P_Q_TAIL, Q_TAIL_LEN);
            P_Q_LABEL, P_A_LABEL: begin
               left_in_field = left_in_field - 16'd1;
               if (left_in_field == 0) begin
                  phase = (phase == P_Q_LABEL) ? P_Q_NAME : P_A_NAME;
               end
            end
            P_Q_POINTER: begin
               phase         = P_Q_TAIL;
               left_in_field = Q_TAIL_LEN;
            end
            P_Q_TAIL: begin
               left_in_field = left_in_field - 16'd1;
               if (left_in_field == 0) begin
                  questions_left = questions_left - 8'd1;
                  phase = (questions_left == 0) ? P_A_NAME : P_Q_NAME;
               end
            end
            P_A_NAME: name_start(b, P_A_LABEL, P_A_POINTER, P_A_FIXED, A_FIXED_LEN);
            P_A_POINTER: begin
               phase         = P_A_FIXED;
               left_in_field = A_FIXED_LEN;
            end
            P_A_FIXED: begin
               idx = A_FIXED_LEN - int'(left_in_field);
               case (idx)
                  0: rr_type = {b, 8'h00};
                  1: rr_type[7:0] = b;
                  8: rr_length = {b, 8'h00};
                  9: rr_length[7:0] = b;
                  default: ;
               endcase
               left_in_field = left_in_field - 16'd1;
               if (left_in_field == 0) begin
                  addr_upper = '0;
                  addr_lower = '0;
                  if (rr_length == 0) begin
                     answer_done();
                  end else begin
                     phase         = P_A_RDATA;
                     left_in_field = rr_length;
                  end
               end
            end
            P_A_RDATA: begin
               if (address_record()) begin
                  addr_upper = {addr_upper[55:0], addr_lower[63:56]};
                  addr_lower = {addr_lower[55:0], b};
               end
               left_in_field = left_in_field - 16'd1;
               if (left_in_field == 0) begin
                  if (address_record()) begin
                     decide(ST_OK);
                  end else begin
                     answer_done();
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void note_byte(req_payload_type item);
         int              pos;
         rsp_payload_type res;
         pos = byte_count;
         if (byte_count <= MAX_MESSAGE_BYTES) begin
            byte_count = byte_count + 10'd1;
         end
         if (phase != P_DECIDED && byte_count <= MAX_MESSAGE_BYTES) begin
            walk_byte(pos, item.data_byte);
         end
         if (item.last_byte) begin
            res = '0;
            if (byte_count > MAX_MESSAGE_BYTES) begin
               res.status = ST_TOO_LONG;
            end else if (byte_count < HEADER_LEN) begin
               res.status = ST_TOO_SHORT;
            end else if (phase == P_DECIDED) begin
               res.status = outcome;
            end else begin
               res.status = ST_TRUNCATED;
            end
            if (res.status == ST_OK) begin
               res.is_ipv6   = (rr_type == RR_TYPE_AAAA);
               res.addr_high = res.is_ipv6 ? addr_upper : 64'd0;
               res.addr_low  = addr_lower;
            end
            expected_q.push_back(res);
            clear_message();
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            $error("result transfer with nothing expected: status %0d", got.status);
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            error_count++;
         end
         if (got.is_ipv6 !== want.is_ipv6) begin
            $error("is_ipv6: expected %0d, actual %0d", want.is_ipv6, got.is_ipv6);
            error_count++;
         end
         if (got.addr_high !== want.addr_high) begin
            $error("addr_high: expected %h, actual %h", want.addr_high, got.addr_high);
            error_count++;
         end
         if (got.addr_low !== want.addr_low) begin
            $error("addr_low: expected %h, actual %h", want.addr_low, got.addr_low);
            error_count++;
         end
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// top of the dns response address extractor testbench: clock, reset, message stimulus
// depends on dre_pkg, dre_tb_pkg and the dns_response_address_extractor rtl
module tb_top;
   import dre_pkg::*;
   import dre_tb_pkg::*;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_write;
   logic            csr_index;
   logic [7:0]      csr_data;

   dns_answer_scoreboard sb;

   // stimulus knobs in percent: idling and stalls per cycle, bad labels per label
   int send_idle_pct;
   int recv_stall_pct;
   int bad_label_pct;
   // register values as last written, steer the message generator
   int cfg_answers;
   int cfg_questions;
   int bytes_sent;

   // message under construction, wire order
   logic [7:0] msg[$];

   dns_response_address_extractor DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // monitor: every transfer is seen at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) begin
            sb.write_register(csr_index, csr_data);
         end
         if (req_valid && !req_stall) begin
            sb.note_byte(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_payload);
         end
      end
   end

   // result side back-pressure, redrawn every falling edge
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
      end
   end

   // one byte transfer; entered and left at a falling edge
   task automatic send_byte(logic [7:0] value, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid             = 1'b1;
      req_payload.data_byte = value;
      req_payload.last_byte = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_message();
      foreach (msg[i]) begin
         send_byte(msg[i], i == msg.size() - 1);
      end
      msg.delete();
   endtask

   // registers change only with no message in flight
   task automatic wait_idle();
      req_valid = 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic program_register(logic index, logic [7:0] value);
      csr_write = 1'b1;
      csr_index = index;
      csr_data  = value;
      @(negedge clock);
      csr_write = 1'b0;
      if (index == CSR_MAX_ANSWERS) begin
         cfg_answers = value;
      end else begin
         cfg_questions = value;
      end
   endtask

   function automatic void put_random(int n);
      repeat (n) msg.push_back(8'($urandom));
   endfunction

   function automatic void put16(logic [15:0] v);
      msg.push_back(v[15:8]);
      msg.push_back(v[7:0]);
   endfunction

   // id, flags, question count, answer count, then random authority/additional counts
   function automatic void put_header(logic [15:0] flags, logic [15:0] qd, logic [15:0] an);
      put16(16'($urandom));
      put16(flags);
      put16(qd);
      put16(an);
      put_random(4);
   endfunction

   // labels of random size, closed by a zero byte or a compression pointer
   function automatic void put_name(int labels, bit pointer_end);
      int len;
      repeat (labels) begin
         if ($urandom_range(99) < bad_label_pct) begin
            msg.push_back(8'($urandom_range(int'(POINTER_MIN) - 1, LABEL_MAX + 1)));
         end
         len = $urandom_range(8, 1);
         msg.push_back(8'(len));
         put_random(len);
      end
      if (pointer_end) begin
         msg.push_back(8'($urandom_range(255, int'(POINTER_MIN))));
         put_random(1);
      end else begin
         msg.push_back(8'h00);
      end
   endfunction

   function automatic void put_question(int labels, bit pointer_end);
      put_name(labels, pointer_end);
      put_random(Q_TAIL_LEN);
   endfunction

   // name, type, class and ttl, rdlength, rdata
   function automatic void put_answer(logic [15:0] rtype, int rlen, int labels,
                                      bit pointer_end);
      put_name(labels, pointer_end);
      put16(rtype);
      put_random(6);
      put16(16'(rlen));
      put_random(rlen);
   endfunction

   // mostly well-formed responses with random content, some broken on purpose
   task automatic random_message();
      int          r;
      int          qd;
      int          an;
      int          lim;
      int          cut;
      logic [15:0] flags;
      flags = (16'($urandom) | FLAG_QR) & ~FLAG_RCODE;
      r = $urandom_range(99);
      if (r < 5) begin
         flags = flags & ~FLAG_QR;
      end else if (r < 10) begin
         flags = flags | 16'($urandom_range(15, 1));
      end
      r = $urandom_range(99);
      if (r < 88) begin
         qd = $urandom_range((cfg_questions < 3) ? cfg_questions : 3, 0);
      end else if (r < 95) begin
         qd = cfg_questions + 1;
      end else begin
         qd = $urandom_range(65535, 256);
      end
      lim = (cfg_answers < 4) ? cfg_answers : 4;
      if (lim == 0) begin
         lim = 3;
      end
      r = $urandom_range(99);
      if (r < 85) begin
         an = $urandom_range(lim, 1);
      end else if (r < 90) begin
         an = 0;
      end else if (r < 95) begin
         an = cfg_answers + 1;
      end else begin
         an = $urandom_range(65535, 256);
      end
      put_header(flags, 16'(qd), 16'(an));
      repeat ((qd < 4) ? qd : 4) put_question($urandom_range(2), $urandom_range(1));
      repeat ((an < 4) ? an : 4) begin
         r = $urandom_range(99);
         if (r < 40) begin
            put_answer(RR_TYPE_A, (r < 32) ? IPV4_BYTES : $urandom_range(6),
                       $urandom_range(2), $urandom_range(1));
         end else if (r < 75) begin
            put_answer(RR_TYPE_AAAA, (r < 67) ? IPV6_BYTES : $urandom_range(20),
                       $urandom_range(2), $urandom_range(1));
         end else begin
            put_answer(16'($urandom), $urandom_range(8), $urandom_range(2),
                       $urandom_range(1));
         end
      end
      // early end, trailing junk, or past the size limit
      r = $urandom_range(99);
      if (r < 12) begin
         cut = $urandom_range(msg.size() - 1, 1);
         while (msg.size() > cut) void'(msg.pop_back());
      end else if (r < 18) begin
         put_random($urandom_range(6, 1));
      end else if (r < 21 && msg.size() <= MAX_MESSAGE_BYTES) begin
         put_random($urandom_range(MAX_MESSAGE_BYTES + 8, MAX_MESSAGE_BYTES + 1) - msg.size());
      end
      send_message();
   endtask

   initial begin
      int ph;
      int start_bytes;
      int n;
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      csr_write      = 1'b0;
      csr_index      = CSR_MAX_ANSWERS;
      csr_data       = 8'd0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      bad_label_pct  = 0;
      cfg_answers    = MAX_ANSWERS_RESET;
      cfg_questions  = MAX_QUESTIONS_RESET;
      bytes_sent     = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed messages, reset register values, no idling
      // ipv4 answer behind one question
      put_header(16'h8180, 16'd1, 16'd1);
      put_question(1, 1'b0);
      put_answer(RR_TYPE_A, IPV4_BYTES, 0, 1'b1);
      send_message();
      // ipv6 answer with all-ones then all-zeros address bytes
      put_header(FLAG_QR, 16'd0, 16'd1);
      msg.push_back(8'h00);
      put16(RR_TYPE_AAAA);
      put_random(6);
      put16(16'(IPV6_BYTES));
      repeat (8) msg.push_back(8'hFF);
      repeat (8) msg.push_back(8'h00);
      send_message();
      // longest label, pointer name, wrong-length records skipped before a match
      put_header(16'hFFF0, 16'd2, 16'd3);
      msg.push_back(8'(LABEL_MAX));
      put_random(LABEL_MAX);
      msg.push_back(8'h00);
      put_random(Q_TAIL_LEN);
      put_question(2, 1'b1);
      put_answer(RR_TYPE_A, 5, 1, 1'b0);
      put_answer(RR_TYPE_AAAA, IPV4_BYTES, 0, 1'b1);
      put_answer(RR_TYPE_AAAA, IPV6_BYTES, 1, 1'b1);
      send_message();
      // not a response, bytes after the decision ignored
      put_header(16'h7FF0, 16'd1, 16'd1);
      put_random(20);
      send_message();
      // server errors
      put_header(16'h800F, 16'd1, 16'd1);
      put_random(3);
      send_message();
      put_header(16'h8001, 16'd0, 16'd1);
      send_message();
      // answer count zero, above limit, high byte set; question count above limit
      put_header(FLAG_QR, 16'd0, 16'd0);
      put_answer(RR_TYPE_A, IPV4_BYTES, 0, 1'b1);
      send_message();
      put_header(FLAG_QR, 16'd0, 16'(MAX_ANSWERS_RESET + 1));
      send_message();
      put_header(FLAG_QR, 16'd0, 16'h0101);
      send_message();
      put_header(FLAG_QR, 16'(MAX_QUESTIONS_RESET + 1), 16'd1);
      send_message();
      put_header(FLAG_QR, 16'h0100, 16'd1);
      send_message();
      // bad label lengths at both ends of the reserved range
      put_header(FLAG_QR, 16'd1, 16'd1);
      msg.push_back(8'(LABEL_MAX + 1));
      put_random(10);
      send_message();
      put_header(FLAG_QR, 16'd0, 16'd1);
      msg.push_back(8'd1);
      put_random(1);
      msg.push_back(POINTER_MIN - 8'd1);
      put_random(4);
      send_message();
      // early ends: right after the header, inside rdata, at a record boundary
      put_header(FLAG_QR, 16'd1, 16'd1);
      send_message();
      put_header(FLAG_QR, 16'd0, 16'd1);
      put_answer(RR_TYPE_A, IPV4_BYTES, 1, 1'b0);
      void'(msg.pop_back());
      send_message();
      put_header(FLAG_QR, 16'd0, 16'd2);
      put_answer(RR_TYPE_CNAME, 3, 1, 1'b1);
      send_message();
      // every record walked, none usable
      put_header(FLAG_QR, 16'd1, 16'd3);
      put_question(1, 1'b1);
      put_answer(RR_TYPE_CNAME, 0, 0, 1'b1);
      put_answer(RR_TYPE_A, IPV6_BYTES, 1, 1'b0);
      put_answer(RR_TYPE_AAAA, IPV4_BYTES, 0, 1'b1);
      send_message();
      // too short: one byte and one byte under a header
      put_random(1);
      send_message();
      put_header(FLAG_QR, 16'd0, 16'd1);
      void'(msg.pop_back());
      send_message();
      // exactly at the size limit, then one byte over
      put_header(FLAG_QR, 16'd0, 16'd1);
      put_answer(RR_TYPE_TXT, MAX_MESSAGE_BYTES - HEADER_LEN - 2 - A_FIXED_LEN, 0, 1'b1);
      send_message();
      put_header(FLAG_QR, 16'd0, 16'd1);
      put_answer(RR_TYPE_TXT, MAX_MESSAGE_BYTES - HEADER_LEN - 2 - A_FIXED_LEN, 0, 1'b1);
      put_random(1);
      send_message();

      // random phases: register settings and idling pattern change together
      bad_label_pct = 3;
      for (ph = 0; ph < 5; ph++) begin
         wait_idle();
         case (ph)
            1: begin
               program_register(CSR_MAX_ANSWERS, 8'd1);
               program_register(CSR_MAX_QUESTIONS, 8'd0);
            end
            2: begin
               program_register(CSR_MAX_ANSWERS, 8'd255);
               program_register(CSR_MAX_QUESTIONS, 8'd255);
            end
            3: begin
               // zero answers allowed: no message can pass the count checks
               program_register(CSR_MAX_ANSWERS, 8'd0);
               program_register(CSR_MAX_QUESTIONS, 8'd3);
            end
            4: begin
               program_register(CSR_MAX_ANSWERS, 8'd6);
               program_register(CSR_MAX_QUESTIONS, 8'd2);
            end
            default: ;
         endcase
         case (ph % 4)
            1: begin
               send_idle_pct  = 73;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 73;
            end
            3: begin
               send_idle_pct  = 15;
               recv_stall_pct = 15;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         start_bytes = bytes_sent;
         while (bytes_sent - start_bytes < 90) begin
            random_message();
         end
      end

      // drain outstanding results, then wait for anything stray
      req_valid = 1'b0;
      for (n = 0; n < 20000 && sb.expected_q.size() != 0; n++) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         $error("%0d expected results never arrived", sb.expected_q.size());
      end
      if (sb.error_count == 0 && sb.expected_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/dre_pkg.sv
src/dns_response_address_extractor.sv
src/dre_checker.sv
tb/sv/dre_tb_pkg.sv
tb/sv/tb_top.sv
